/* rtl/core/gcsp_pkg.sv */
// shared types, codes and constants of the gesture controlled sample player
package gcsp_pkg;

  // default store depth and register reset values
  localparam int SAMPLE_DEPTH_DEF = 4096;
  localparam logic [7:0]  PWM_TOP_RST    = 8'd199;
  localparam logic [12:0] SAMPLE_LEN_RST = 13'd4096;
  localparam logic [12:0] RANGE_NEAR_RST = 13'd80;
  localparam logic [12:0] RANGE_FAR_RST  = 13'd800;

  // gesture timing in milliseconds
  localparam logic [31:0] ENTRY_GAP_MS  = 32'd500;
  localparam logic [31:0] SCRATCH_WIN_MS = 32'd300;
  localparam logic [31:0] HOLD_MS       = 32'd300;

  // rates, counts and steps
  localparam logic [3:0] RATE_BASE    = 4'd5;
  localparam logic [3:0] SCRATCH_RATE = 4'd2;
  localparam logic [7:0] MIN_ENTRIES  = 8'd2;
  localparam logic [7:0] FAST_ENTRIES = 8'd4;
  localparam logic signed [3:0] STEP_FWD  = 4'sd1;
  localparam logic signed [3:0] STEP_SLOW = 4'sd3;
  localparam logic signed [3:0] STEP_FAST = 4'sd6;

  // rate ratio divider widths: 10 * (d - near) over (far - near)
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 13;
  localparam int DIV_QUO_W = 4;

  // command codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SENSE = 2'd1,
    FUNC_START = 2'd2,
    FUNC_LOAD  = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PWM_TOP    = 2'd0,
    REG_SAMPLE_LEN = 2'd1,
    REG_RANGE_NEAR = 2'd2,
    REG_RANGE_FAR  = 2'd3
  } cfg_reg_t;

  // command word
  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] distance_q4;
    logic [31:0] time_ms;
    logic [11:0] sample_address;
    logic [7:0]  sample_value;
  } cmd_word_t;

  // result word
  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       scratch_active;
  } res_word_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

/* rtl/core/gcsp_store.sv */
// sample store: one write port, one registered read port
module gcsp_store #(
  parameter int DEPTH = gcsp_pkg::SAMPLE_DEPTH_DEF,
  parameter int AW    = $clog2(gcsp_pkg::SAMPLE_DEPTH_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/gcsp_div.sv */
// restoring divider for the distance ratio, one quotient bit per cycle
module gcsp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gcsp_pkg::DIV_NUM_W-1:0] num,
  input  logic [gcsp_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [gcsp_pkg::DIV_QUO_W-1:0] quo
);

  localparam int NW = gcsp_pkg::DIV_NUM_W;
  localparam int QW = gcsp_pkg::DIV_QUO_W;
  localparam int CW = $clog2(QW);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          ge;

  assign ge = (rem >= dsh);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: compare, subtract, shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NW'({den, {(QW-1){1'b0}}});
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

/* rtl/core/gesture_controlled_sample_player.sv */
// top level: command sequencer, gesture state, playback and pwm scaling
//
//   channel  direction  word         handshake
//   cmd      in         cmd_word_t   cmd_valid / cmd_ready
//   res      out        res_word_t   res_valid / res_ready
//   cfg      in         index, data  cfg_valid / cfg_ready (always ready)
//
// one command at a time. a divided tick while playing runs ST_EXEC (command and
// store read), ST_RDAT (multiply), ST_SCALE and ST_RES (result load); a divided
// tick while stopped runs ST_EXEC, ST_RES; start, load and other ticks ST_EXEC only.
// an in range sensor word on the normal path waits in ST_DIVW for the 4 step ratio
// divider, other sensor words run ST_EXEC only. synchronous reset sets control state
// to reset values, not datapath or store contents. a waiting result stalls ST_RES.
module gesture_controlled_sample_player #(
  parameter int SAMPLE_DEPTH = gcsp_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  gcsp_pkg::cmd_word_t cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output gcsp_pkg::res_word_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int LW = AW + 1;
  localparam int PW = AW + 2;
  localparam int EW = (LW > 13) ? LW : 13;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_RDAT  = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_RES   = 6'b010000,
    ST_DIVW  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [7:0]  pwm_top;
  logic [12:0] sample_length;
  logic [12:0] range_near;
  logic [12:0] range_far;

  // player and gesture state
  logic [AW-1:0]     pos;
  logic [7:0]        tick_cnt;
  logic              playing;
  logic              scratch_mode;
  logic signed [3:0] scratch_step;
  logic [3:0]        normal_rate;
  logic              hand_present;
  logic [31:0]       last_entry_ms;
  logic [31:0]       presence_ms;
  logic [7:0]        entry_count;
  logic              dir_neg;

  // datapath registers
  gcsp_pkg::cmd_word_t cmd_r;
  logic [7:0]  duty_r;
  logic        sa_r;
  logic [15:0] prod;

  // store and divider hookup
  logic          st_we;
  logic          st_re;
  logic [7:0]    st_rdata;
  logic          div_start;
  logic          div_done;
  logic [gcsp_pkg::DIV_QUO_W-1:0] div_quo;

  // tick divider
  logic [7:0] tick_inc;
  logic [3:0] tick_rate;
  logic       tick_fire;

  // position stepping
  logic [EW-1:0]       len_w;
  logic [LW-1:0]       eff_len;
  logic [LW-1:0]       len_m1;
  logic [AW-1:0]       pos_eff;
  logic signed [3:0]   step_use;
  logic signed [PW-1:0] pos_sum;
  logic [AW-1:0]       pos_nx;

  // sample shaping
  logic [7:0] shaped;
  logic [7:0] smp_off;
  logic [16:0] scale_sum;

  // sensor evaluation
  logic              in_range;
  logic              new_entry;
  logic [31:0]       last_eff;
  logic [31:0]       pres_eff;
  logic [7:0]        cnt1;
  logic [7:0]        cnt2;
  logic [31:0]       dl;
  logic [31:0]       dp;
  logic              scr_hit;
  logic              norm_hit;
  logic              dir_eff;
  logic signed [3:0] mag;
  logic signed [3:0] step_new;
  logic [12:0]       span;
  logic [12:0]       dofs;
  logic [gcsp_pkg::DIV_NUM_W-1:0] div_num;

  logic load_ok;
  logic res_free;

  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign res_free  = !res_valid || res_ready;

  // tick divider compare
  always_comb begin
    tick_inc  = tick_cnt + 8'd1;
    tick_rate = scratch_mode ? gcsp_pkg::SCRATCH_RATE : normal_rate;
    tick_fire = (tick_inc >= {4'b0, tick_rate});
  end

  // effective length and next position with wrap at both ends
  always_comb begin
    len_w = EW'(sample_length);
    if (len_w == '0) begin
      eff_len = LW'(1);
    end else if (len_w > EW'(SAMPLE_DEPTH)) begin
      eff_len = LW'(SAMPLE_DEPTH);
    end else begin
      eff_len = len_w[LW-1:0];
    end
    len_m1   = eff_len - 1'b1;
    pos_eff  = ({1'b0, pos} >= eff_len) ? '0 : pos;
    step_use = scratch_mode ? scratch_step : gcsp_pkg::STEP_FWD;
    pos_sum  = $signed({2'b00, pos_eff}) + PW'(step_use);
    if (pos_sum < 0) begin
      pos_nx = len_m1[AW-1:0];
    end else if (pos_sum >= $signed({1'b0, eff_len})) begin
      pos_nx = '0;
    end else begin
      pos_nx = pos_sum[AW-1:0];
    end
  end

  // recentre, times four, clamp, back to unsigned
  always_comb begin
    smp_off = st_rdata - 8'd96;
    if (st_rdata < 8'd96) begin
      shaped = 8'd0;
    end else if (st_rdata >= 8'd160) begin
      shaped = 8'd255;
    end else begin
      shaped = {smp_off[5:0], 2'b00};
    end
    // floor(prod / 255) for prod below 2^16
    scale_sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
  end

  // gesture decode for a sensor word
  always_comb begin
    in_range  = (cmd_r.distance_q4 >= range_near) && (cmd_r.distance_q4 <= range_far);
    new_entry = !hand_present;
    last_eff  = new_entry ? cmd_r.time_ms : last_entry_ms;
    pres_eff  = new_entry ? cmd_r.time_ms : presence_ms;
    cnt1      = new_entry ? entry_count + 8'd1 : entry_count;
    dir_eff   = new_entry ? !dir_neg : dir_neg;
    dl        = cmd_r.time_ms - last_eff;
    dp        = cmd_r.time_ms - pres_eff;
    cnt2      = (dl > gcsp_pkg::ENTRY_GAP_MS) ? 8'd0 : cnt1;
    scr_hit   = (cnt2 >= gcsp_pkg::MIN_ENTRIES) && (dl < gcsp_pkg::SCRATCH_WIN_MS);
    norm_hit  = !scr_hit && (dp > gcsp_pkg::HOLD_MS);
    mag       = (cnt2 >= gcsp_pkg::FAST_ENTRIES) ? gcsp_pkg::STEP_FAST
                                                 : gcsp_pkg::STEP_SLOW;
    step_new  = dir_eff ? -mag : mag;
    span      = range_far - range_near;
    dofs      = cmd_r.distance_q4 - range_near;
    div_num   = {1'b0, dofs, 3'b000} + {3'b000, dofs, 1'b0};
  end

  assign load_ok = EW'(cmd_r.sample_address) < EW'(SAMPLE_DEPTH);

  // store and divider strobes from the command cycle
  always_comb begin
    st_we     = 1'b0;
    st_re     = 1'b0;
    div_start = 1'b0;
    if (state == ST_EXEC) begin
      case (cmd_r.func)
        gcsp_pkg::FUNC_TICK:  st_re = tick_fire && playing;
        gcsp_pkg::FUNC_SENSE: div_start = in_range && norm_hit && (span != '0);
        gcsp_pkg::FUNC_LOAD:  st_we = load_ok;
        default:              st_we = 1'b0;
      endcase
    end
  end

  gcsp_store #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (AW'(cmd_r.sample_address)),
    .wdata (cmd_r.sample_value),
    .re    (st_re),
    .raddr (pos_eff),
    .rdata (st_rdata)
  );

  gcsp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (span),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_top       <= gcsp_pkg::PWM_TOP_RST;
      sample_length <= gcsp_pkg::SAMPLE_LEN_RST;
      range_near    <= gcsp_pkg::RANGE_NEAR_RST;
      range_far     <= gcsp_pkg::RANGE_FAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcsp_pkg::REG_PWM_TOP:    pwm_top       <= cfg_data[7:0];
        gcsp_pkg::REG_SAMPLE_LEN: sample_length <= cfg_data;
        gcsp_pkg::REG_RANGE_NEAR: range_near    <= cfg_data;
        gcsp_pkg::REG_RANGE_FAR:  range_far     <= cfg_data;
        default:                  pwm_top       <= pwm_top;
      endcase
    end
  end

  // command sequencer and player state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos           <= '0;
      tick_cnt      <= '0;
      playing       <= 1'b0;
      scratch_mode  <= 1'b0;
      scratch_step  <= gcsp_pkg::STEP_FWD;
      normal_rate   <= gcsp_pkg::RATE_BASE;
      hand_present  <= 1'b0;
      last_entry_ms <= '0;
      presence_ms   <= '0;
      entry_count   <= '0;
      dir_neg       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // result taken, unless a new one loads in the same cycle
      if (res_valid && res_ready && state != ST_RES) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd_r.func)
            gcsp_pkg::FUNC_TICK: begin
              if (!tick_fire) begin
                tick_cnt <= tick_inc;
                state    <= ST_IDLE;
              end else begin
                tick_cnt <= '0;
                if (playing) begin
                  pos   <= pos_nx;
                  state <= ST_RDAT;
                end else begin
                  state <= ST_RES;
                end
              end
            end
            gcsp_pkg::FUNC_SENSE: begin
              state <= div_start ? ST_DIVW : ST_IDLE;
              if (!in_range) begin
                playing      <= 1'b0;
                scratch_mode <= 1'b0;
                hand_present <= 1'b0;
              end else begin
                last_entry_ms <= last_eff;
                presence_ms   <= pres_eff;
                entry_count   <= cnt2;
                dir_neg       <= dir_eff;
                playing       <= 1'b1;
                hand_present  <= 1'b1;
                if (scr_hit) begin
                  scratch_mode <= 1'b1;
                  scratch_step <= step_new;
                end else if (norm_hit) begin
                  scratch_mode <= 1'b0;
                  scratch_step <= gcsp_pkg::STEP_FWD;
                  if (span == '0) begin
                    normal_rate <= gcsp_pkg::RATE_BASE;
                  end
                end
              end
            end
            gcsp_pkg::FUNC_START: begin
              playing <= 1'b1;
              pos     <= '0;
              state   <= ST_IDLE;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_RDAT: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_RES;
        end
        ST_RES: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            normal_rate <= gcsp_pkg::RATE_BASE + div_quo;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    if (state == ST_EXEC) begin
      duty_r <= {1'b0, pwm_top[7:1]};
      sa_r   <= scratch_mode;
    end
    if (state == ST_RDAT) begin
      prod <= 16'(shaped) * 16'(pwm_top);
    end
    if (state == ST_SCALE) begin
      duty_r <= scale_sum[15:8];
    end
    if (state == ST_RES && res_free) begin
      res.pwm_duty       <= duty_r;
      res.scratch_active <= sa_r;
    end
  end

  // checks
  a_pos_in_store: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos} < LW'(SAMPLE_DEPTH))
    else $error("play position beyond store depth");

  a_tick_below_rate: assert property (@(posedge clk) disable iff (rst)
    tick_cnt < 8'd15)
    else $error("tick divider count past the largest rate");

  a_rate_floor: assert property (@(posedge clk) disable iff (rst)
    normal_rate >= gcsp_pkg::RATE_BASE)
    else $error("normal rate below base");

  a_step_set: assert property (@(posedge clk) disable iff (rst)
    scratch_step == 4'sd1 || scratch_step == 4'sd3 || scratch_step == -4'sd3 ||
    scratch_step == 4'sd6 || scratch_step == -4'sd6)
    else $error("scratch step outside its set");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVW)
    else $error("divider finished with no sensor word waiting");

  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RES && res_free) |=> res_valid)
    else $error("result word not presented");

endmodule
